@@ rtl/core/frm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package frm_pkg;

    localparam int MAX_POINTS = 4096;

    localparam int SKIP_W = 13;
    localparam int GAIN_W = 16;
    localparam int SAMPLE_W = 16;
    localparam int RMS_W = 25;
    localparam int USED_W = 13;
    localparam int DATA_W = 16;
    localparam int CFG_IDX_W = 2;

    localparam int POS_W = $clog2(MAX_POINTS + 1);
    localparam int CNT_W = (POS_W > SKIP_W) ? POS_W : SKIP_W;

    localparam int SUM_W = 64;
    localparam int ROOT_W = SUM_W / 2;
    localparam int SQ_REM_W = ROOT_W + 2;
    localparam int DIV_STEPS = SUM_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int STEP_W = $clog2(DIV_STEPS);

    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_STEPS - 1);
    localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(SQRT_STEPS - 1);
    localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(1);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);

    localparam logic [CFG_IDX_W-1:0] REG_LINE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_B = 2'd3;

    typedef struct packed {
        logic take;
        logic load;
        logic div_step;
        logic sqrt_step;
    } frm_cmd_t;

    typedef struct packed {
        logic last_done;
    } frm_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/frm_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module frm_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            sample_valid,
    input  wire logic            frame_end,
    output logic                 sample_stall,
    output logic                 result_valid,
    input  wire logic            result_stall,
    output frm_pkg::frm_cmd_t    cmd,
    input  wire frm_pkg::frm_sts_t sts
);

    localparam logic [2:0] ST_ACCUM = 3'd0;
    localparam logic [2:0] ST_DRAIN = 3'd1;
    localparam logic [2:0] ST_DIV = 3'd2;
    localparam logic [2:0] ST_SQRT = 3'd3;
    localparam logic [2:0] ST_OUT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [frm_pkg::STEP_W-1:0] step_reg;
    logic [frm_pkg::STEP_W-1:0] step_next;
    logic take;

    assign sample_stall = (state_reg != ST_ACCUM);
    assign result_valid = (state_reg == ST_OUT);
    assign take = sample_valid && !sample_stall;

    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        cmd.take = take;
        cmd.load = 1'b0;
        cmd.div_step = 1'b0;
        cmd.sqrt_step = 1'b0;
        unique case (state_reg)
            ST_ACCUM:
            begin
                if (take && frame_end)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (sts.last_done)
                begin
                    cmd.load = 1'b1;
                    step_next = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == frm_pkg::DIV_LAST)
                begin
                    step_next = '0;
                    state_next = ST_SQRT;
                end
                else
                begin
                    step_next = step_reg + frm_pkg::STEP_ONE;
                end
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (step_reg == frm_pkg::SQRT_LAST)
                begin
                    step_next = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    step_next = step_reg + frm_pkg::STEP_ONE;
                end
            end
            ST_OUT:
            begin
                if (!result_stall)
                begin
                    state_next = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCUM;
            step_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.div_step, cmd.sqrt_step}))
        else $error("more than one datapath command at once");

    assert property (@(posedge clk) disable iff (!rst_n)
        sts.last_done |-> (state_reg == ST_DRAIN))
        else $error("frame close seen outside the drain state");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == ST_SQRT))
        else $error("result raised without a finished root");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_DIV) && (step_reg == '0))
        else $error("divide did not start after load");

endmodule

`default_nettype wire

@@ rtl/core/frm_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module frm_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire frm_pkg::frm_cmd_t                 cmd,
    output frm_pkg::frm_sts_t                      sts,
    input  wire logic                              line_mode,
    input  wire logic [frm_pkg::SKIP_W-1:0]        skip_count,
    input  wire logic [frm_pkg::GAIN_W-1:0]        gain_a,
    input  wire logic [frm_pkg::GAIN_W-1:0]        gain_b,
    input  wire logic signed [frm_pkg::SAMPLE_W-1:0] sample_a,
    input  wire logic signed [frm_pkg::SAMPLE_W-1:0] sample_b,
    input  wire logic                              frame_end,
    output logic [frm_pkg::RMS_W-1:0]              rms_value,
    output logic [frm_pkg::USED_W-1:0]             used_samples,
    output logic                                   empty_frame,
    output logic                                   frame_overflow
);

    localparam int PROD_W = frm_pkg::SAMPLE_W + frm_pkg::GAIN_W + 1;
    localparam int DIFF_W = PROD_W + 1;
    localparam int SHIFT_W = DIFF_W - 8;
    localparam int MAG_W = SHIFT_W - 1;
    localparam int SQ_W = 2 * MAG_W;
    localparam int CNT_W = frm_pkg::CNT_W;
    localparam int SUM_W = frm_pkg::SUM_W;
    localparam int ROOT_W = frm_pkg::ROOT_W;
    localparam int SQ_REM_W = frm_pkg::SQ_REM_W;

    logic [CNT_W-1:0] pos_reg;
    logic [CNT_W-1:0] used_reg;
    logic             ovf_reg;
    logic [CNT_W-1:0] skip_ext;
    logic             use_now;

    logic signed [PROD_W-1:0] s1_pa_reg;
    logic signed [PROD_W-1:0] s1_pb_reg;
    logic signed [PROD_W-1:0] pa_next;
    logic signed [PROD_W-1:0] pb_next;
    logic                     s1_use_reg;
    logic                     s1_last_reg;

    logic signed [DIFF_W-1:0]  diff;
    logic signed [SHIFT_W-1:0] shifted;
    logic [SHIFT_W-1:0]        abs_val;
    logic [MAG_W-1:0]          s2_mag_reg;
    logic                      s2_use_reg;
    logic                      s2_last_reg;

    logic [SQ_W-1:0] s3_sq_reg;
    logic            s3_use_reg;
    logic            s3_last_reg;
    logic            s4_last_reg;

    logic [SUM_W-1:0] sum_reg;

    logic [SUM_W-1:0] x_reg;
    logic [CNT_W-1:0] divisor_reg;
    logic [CNT_W-1:0] rem_reg;
    logic [CNT_W:0]   div_trial;
    logic             div_bit;

    logic [SQ_REM_W-1:0] sq_rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [SQ_REM_W+1:0] sq_rem_t;
    logic [SQ_REM_W+1:0] sq_trial;
    logic                sq_bit;

    logic [frm_pkg::USED_W-1:0] out_used_reg;
    logic                       out_empty_reg;
    logic                       out_ovf_reg;

    always_comb
    begin
        skip_ext = '0;
        skip_ext[frm_pkg::SKIP_W-1:0] = skip_count;
    end

    assign use_now = (pos_reg < frm_pkg::MAX_CNT) && (pos_reg >= skip_ext);

    assign pa_next = sample_a * $signed({1'b0, gain_a});

    always_comb
    begin
        pb_next = '0;
        if (line_mode)
        begin
            pb_next = sample_b * $signed({1'b0, gain_b});
        end
    end

    assign diff = DIFF_W'(s1_pa_reg) - DIFF_W'(s1_pb_reg);
    assign shifted = SHIFT_W'(diff >>> 8);
    assign abs_val = shifted[SHIFT_W-1] ? SHIFT_W'(-shifted) : SHIFT_W'(shifted);

    assign div_trial = {rem_reg, x_reg[SUM_W-1]};
    assign div_bit = (div_trial >= {1'b0, divisor_reg});

    assign sq_rem_t = {sq_rem_reg, x_reg[SUM_W-1:SUM_W-2]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign sq_bit = (sq_rem_t >= sq_trial);

    assign sts.last_done = s4_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_use_reg <= 1'b0;
            s1_last_reg <= 1'b0;
            s2_use_reg <= 1'b0;
            s2_last_reg <= 1'b0;
            s3_use_reg <= 1'b0;
            s3_last_reg <= 1'b0;
            s4_last_reg <= 1'b0;
            pos_reg <= '0;
            used_reg <= '0;
            ovf_reg <= 1'b0;
            sum_reg <= '0;
        end
        else
        begin
            s1_use_reg <= cmd.take && use_now;
            s1_last_reg <= cmd.take && frame_end;
            s2_use_reg <= s1_use_reg;
            s2_last_reg <= s1_last_reg;
            s3_use_reg <= s2_use_reg;
            s3_last_reg <= s2_last_reg;
            s4_last_reg <= s3_last_reg;
            if (cmd.load)
            begin
                pos_reg <= '0;
                used_reg <= '0;
                ovf_reg <= 1'b0;
                sum_reg <= '0;
            end
            else
            begin
                if (cmd.take)
                begin
                    if (pos_reg >= frm_pkg::MAX_CNT)
                    begin
                        ovf_reg <= 1'b1;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + frm_pkg::CNT_ONE;
                    end
                    if (use_now)
                    begin
                        used_reg <= used_reg + frm_pkg::CNT_ONE;
                    end
                end
                if (s3_use_reg)
                begin
                    sum_reg <= sum_reg + SUM_W'(s3_sq_reg);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            s1_pa_reg <= pa_next;
            s1_pb_reg <= pb_next;
        end
        s2_mag_reg <= abs_val[MAG_W-1:0];
        s3_sq_reg <= s2_mag_reg * s2_mag_reg;

        if (cmd.load)
        begin
            x_reg <= sum_reg;
            divisor_reg <= used_reg;
            rem_reg <= '0;
            sq_rem_reg <= '0;
            root_reg <= '0;
            out_used_reg <= used_reg[frm_pkg::USED_W-1:0];
            out_empty_reg <= (used_reg == '0);
            out_ovf_reg <= ovf_reg;
        end
        else if (cmd.div_step)
        begin
            if (div_bit)
            begin
                rem_reg <= CNT_W'(div_trial - {1'b0, divisor_reg});
            end
            else
            begin
                rem_reg <= div_trial[CNT_W-1:0];
            end
            x_reg <= {x_reg[SUM_W-2:0], div_bit};
        end
        else if (cmd.sqrt_step)
        begin
            if (sq_bit)
            begin
                sq_rem_reg <= SQ_REM_W'(sq_rem_t - sq_trial);
            end
            else
            begin
                sq_rem_reg <= sq_rem_t[SQ_REM_W-1:0];
            end
            root_reg <= {root_reg[ROOT_W-2:0], sq_bit};
            x_reg <= {x_reg[SUM_W-3:0], 2'b00};
        end
    end

    assign rms_value = out_empty_reg ? '0 : root_reg[frm_pkg::RMS_W-1:0];
    assign used_samples = out_used_reg;
    assign empty_frame = out_empty_reg;
    assign frame_overflow = out_ovf_reg;

endmodule

`default_nettype wire

@@ rtl/core/frame_rms_meter.sv @@
// Samples are taken one per cycle while a frame is being summed.
// The word that closes a frame holds the input while the multiply and square
// pipeline drains and then through the bit-serial divide and the bit-serial
// square root; then the result is held until taken.
// Reset clears the sums, counters and control; gains reset to unity (256),
// skip count and line mode to zero.
`timescale 1ns / 1ps
`default_nettype none

module frame_rms_meter (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                sample_valid,
    output logic                                     sample_stall,
    input  wire logic signed [frm_pkg::SAMPLE_W-1:0] sample_a,
    input  wire logic signed [frm_pkg::SAMPLE_W-1:0] sample_b,
    input  wire logic                                frame_end,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output logic [frm_pkg::RMS_W-1:0]                rms_value,
    output logic [frm_pkg::USED_W-1:0]               used_samples,
    output logic                                     empty_frame,
    output logic                                     frame_overflow,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [frm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [frm_pkg::DATA_W-1:0]          cfg_data
);

    logic                         line_mode_reg;
    logic [frm_pkg::SKIP_W-1:0]   skip_count_reg;
    logic [frm_pkg::GAIN_W-1:0]   gain_a_reg;
    logic [frm_pkg::GAIN_W-1:0]   gain_b_reg;
    frm_pkg::frm_cmd_t            cmd;
    frm_pkg::frm_sts_t            sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_mode_reg <= 1'b0;
            skip_count_reg <= '0;
            gain_a_reg <= frm_pkg::GAIN_RESET;
            gain_b_reg <= frm_pkg::GAIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                frm_pkg::REG_LINE_MODE:  line_mode_reg <= cfg_data[0];
                frm_pkg::REG_SKIP_COUNT: skip_count_reg <= cfg_data[frm_pkg::SKIP_W-1:0];
                frm_pkg::REG_GAIN_A:     gain_a_reg <= cfg_data[frm_pkg::GAIN_W-1:0];
                frm_pkg::REG_GAIN_B:     gain_b_reg <= cfg_data[frm_pkg::GAIN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    frm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .frame_end    (frame_end),
        .sample_stall (sample_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .sts          (sts)
    );

    frm_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .line_mode      (line_mode_reg),
        .skip_count     (skip_count_reg),
        .gain_a         (gain_a_reg),
        .gain_b         (gain_b_reg),
        .sample_a       (sample_a),
        .sample_b       (sample_b),
        .frame_end      (frame_end),
        .rms_value      (rms_value),
        .used_samples   (used_samples),
        .empty_frame    (empty_frame),
        .frame_overflow (frame_overflow)
    );

endmodule

`default_nettype wire

@@ tb/tb_frame_rms_meter.sv @@
`timescale 1ns / 1ps

module tb_frame_rms_meter;

    import frm_pkg::*;

    localparam int RANDOM_ITEMS = 1000;
    localparam int PHASE_ITEMS = 130;
    localparam int SETTLE_CYCLES = 120;
    localparam int LONG_HOLD = 300;
    localparam int IDLE_LIMIT = 3000;

    typedef struct {
        logic [RMS_W-1:0]  rms;
        logic [USED_W-1:0] used;
        logic              empty;
        logic              overflow;
    } frame_result_t;

    class rms_tracker;
        bit                 line_mode;
        bit [SKIP_W-1:0]    skip_count;
        bit [GAIN_W-1:0]    gain_a;
        bit [GAIN_W-1:0]    gain_b;
        bit [63:0]          square_sum;
        int unsigned        frame_pos;
        int unsigned        used_total;
        bit                 overflow_seen;
        frame_result_t      pending_frames[$];
        int                 mismatches;
        int                 frames_checked;

        function new();
            line_mode = 1'b0;
            skip_count = '0;
            gain_a = GAIN_RESET;
            gain_b = GAIN_RESET;
            square_sum = '0;
            frame_pos = 0;
            used_total = 0;
            overflow_seen = 1'b0;
            mismatches = 0;
            frames_checked = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
            case (idx)
                REG_LINE_MODE:  line_mode = data[0];
                REG_SKIP_COUNT: skip_count = data[SKIP_W-1:0];
                REG_GAIN_A:     gain_a = data;
                REG_GAIN_B:     gain_b = data;
                default:        ;
            endcase
        endfunction

        function bit [31:0] root_floor(bit [63:0] v);
            bit [31:0] r;
            bit [31:0] trial;
            r = '0;
            for (int b = 31; b >= 0; b--)
            begin
                trial = r | (32'd1 << b);
                if (64'(trial) * 64'(trial) <= v)
                    r = trial;
            end
            return r;
        endfunction

        function void take_sample(logic signed [SAMPLE_W-1:0] a,
                                  logic signed [SAMPLE_W-1:0] b, logic last);
            longint        scaled;
            bit [63:0]     mag;
            frame_result_t res;
            if (frame_pos >= MAX_POINTS)
            begin
                overflow_seen = 1'b1;
            end
            else
            begin
                if (frame_pos >= skip_count)
                begin
                    scaled = longint'(a) * longint'(gain_a);
                    if (line_mode)
                        scaled -= longint'(b) * longint'(gain_b);
                    scaled = scaled >>> 8;
                    mag = (scaled < 0) ? -scaled : scaled;
                    square_sum += mag * mag;
                    used_total++;
                end
                frame_pos++;
            end
            if (last)
            begin
                res.rms = (used_total != 0) ? RMS_W'(root_floor(square_sum / used_total))
                                            : '0;
                res.used = USED_W'(used_total);
                res.empty = (used_total == 0);
                res.overflow = overflow_seen;
                pending_frames.push_back(res);
                square_sum = '0;
                frame_pos = 0;
                used_total = 0;
                overflow_seen = 1'b0;
            end
        endfunction

        function void match_frame(logic [RMS_W-1:0] rms, logic [USED_W-1:0] used,
                                  logic empty, logic overflow);
            frame_result_t exp_res;
            if (pending_frames.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result word with no frame pending: rms %0d used %0d",
                             rms, used);
                return;
            end
            exp_res = pending_frames.pop_front();
            if (rms !== exp_res.rms || used !== exp_res.used || empty !== exp_res.empty
                    || overflow !== exp_res.overflow)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: frame %0d expected rms %0d used %0d empty %0b ovf %0b",
                             frames_checked, exp_res.rms, exp_res.used, exp_res.empty,
                             exp_res.overflow);
                    $display("       got rms %0d used %0d empty %0b ovf %0b",
                             rms, used, empty, overflow);
                end
            end
            frames_checked++;
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        sample_valid = 1'b0;
    logic                        sample_stall;
    logic signed [SAMPLE_W-1:0]  sample_a = '0;
    logic signed [SAMPLE_W-1:0]  sample_b = '0;
    logic                        frame_end = 1'b0;
    logic                        result_valid;
    logic                        result_stall = 1'b0;
    logic [RMS_W-1:0]            rms_value;
    logic [USED_W-1:0]           used_samples;
    logic                        empty_frame;
    logic                        frame_overflow;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index = '0;
    logic [DATA_W-1:0]           cfg_data = '0;

    rms_tracker tracker = new();
    int         burst_left = 0;
    bit         gaps_on = 1'b0;
    bit         long_hold_req = 1'b0;
    int         idle_cycles = 0;

    frame_rms_meter dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .sample_a       (sample_a),
        .sample_b       (sample_b),
        .frame_end      (frame_end),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .rms_value      (rms_value),
        .used_samples   (used_samples),
        .empty_frame    (empty_frame),
        .frame_overflow (frame_overflow),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                tracker.set_reg(cfg_index, cfg_data);
            if (sample_valid && !sample_stall)
                tracker.take_sample(sample_a, sample_b, frame_end);
            if (result_valid && !result_stall)
                tracker.match_frame(rms_value, used_samples, empty_frame, frame_overflow);
            if ((cfg_valid && cfg_ready) || (sample_valid && !sample_stall)
                    || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin : result_sink
        int mode;
        int mode_left;
        int tick;
        int hold_left;
        mode = 0;
        mode_left = 0;
        tick = 0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (hold_left == 0 && long_hold_req)
            begin
                hold_left = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(16, 200);
                end
                mode_left--;
                case (mode)
                    0:       result_stall <= 1'b0;
                    1:       result_stall <= ($urandom_range(0, 99) < 40);
                    default: result_stall <= ((tick % 7) < 3);
                endcase
            end
        end
    end

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] a,
                               input logic signed [SAMPLE_W-1:0] b, input logic last);
        sample_valid <= 1'b1;
        sample_a <= a;
        sample_b <= b;
        frame_end <= last;
        do @(posedge clk); while (sample_stall);
        @(negedge clk);
    endtask

    task automatic offer_sample(input logic signed [SAMPLE_W-1:0] a,
                                input logic signed [SAMPLE_W-1:0] b, input logic last);
        if (gaps_on && burst_left == 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left != 0)
            burst_left--;
        send_sample(a, b, last);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic load_settings(input logic [DATA_W-1:0] lm, input logic [DATA_W-1:0] skip,
                                 input logic [DATA_W-1:0] ga, input logic [DATA_W-1:0] gb);
        write_reg(REG_LINE_MODE, lm);
        write_reg(REG_SKIP_COUNT, skip);
        write_reg(REG_GAIN_A, ga);
        write_reg(REG_GAIN_B, gb);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_frames_done();
        sample_valid <= 1'b0;
        while (tracker.pending_frames.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return '0;
            3:       return SAMPLE_W'($signed($urandom_range(0, 15)) - 8);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 16'hFFFF;
            2:       return GAIN_RESET;
            default: return DATA_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_skip();
        logic [SKIP_W-1:0] skip;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: skip = SKIP_W'($urandom_range(0, 3));
            6, 7:             skip = SKIP_W'($urandom_range(4, 20));
            8:                skip = SKIP_W'($urandom_range(0, 8191));
            default:          skip = MAX_CNT;
        endcase
        return {3'($urandom), skip};
    endfunction

    initial
    begin : stimulus
        int random_items;
        int phase_items;
        int phase_no;
        int flen;
        random_items = 0;
        phase_no = 0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_sample(16'sd32767, 16'sd0, 1'b1);
        send_sample(16'sh8000, 16'sd12345, 1'b1);
        send_sample(16'sd0, 16'sd0, 1'b1);
        send_sample(16'sd3, 16'sd0, 1'b0);
        send_sample(-16'sd4, 16'sd0, 1'b0);
        send_sample(16'sd100, 16'sd0, 1'b1);
        wait_frames_done();
        load_settings(16'd1, 16'd0, 16'hFFFF, 16'hFFFF);
        send_sample(16'sd32767, 16'sh8000, 1'b1);
        send_sample(16'sh8000, 16'sd32767, 1'b1);
        send_sample(-16'sd1, 16'sd0, 1'b1);
        wait_frames_done();
        write_reg(REG_GAIN_A, 16'd0);
        cfg_valid <= 1'b0;
        send_sample(16'sd12345, 16'sh8000, 1'b1);
        wait_frames_done();
        load_settings(16'hFFFE, 16'hE002, 16'h0180, 16'd256);
        send_sample(16'sd100, 16'sd0, 1'b0);
        send_sample(16'sd200, 16'sd0, 1'b1);
        send_sample(16'sd100, 16'sd0, 1'b0);
        send_sample(16'sd200, 16'sd0, 1'b0);
        send_sample(-16'sd300, 16'sd0, 1'b1);
        wait_frames_done();
        write_reg(REG_SKIP_COUNT, 16'(MAX_POINTS));
        cfg_valid <= 1'b0;
        send_sample(16'sd5, 16'sd0, 1'b0);
        send_sample(-16'sd5, 16'sd0, 1'b1);
        wait_frames_done();
        write_reg(REG_SKIP_COUNT, 16'hFFFF);
        cfg_valid <= 1'b0;
        send_sample(16'sd7, 16'sd7, 1'b1);

        while (random_items < RANDOM_ITEMS)
        begin
            wait_frames_done();
            load_settings(DATA_W'($urandom), pick_skip(), pick_gain(), pick_gain());
            gaps_on = (phase_no % 3) != 1;
            burst_left = 0;
            if (phase_no == 2)
                long_hold_req = 1'b1;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                flen = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48)
                                                   : $urandom_range(1, 16);
                for (int k = 0; k < flen; k++)
                    offer_sample(pick_sample(), pick_sample(), k == flen - 1);
                phase_items += flen;
            end
            random_items += phase_items;
            phase_no++;
        end
        wait_frames_done();

        if (tracker.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ frame_rms_meter.f @@
rtl/core/frm_pkg.sv
rtl/core/frm_ctrl.sv
rtl/core/frm_datapath.sv
rtl/core/frame_rms_meter.sv
tb/tb_frame_rms_meter.sv
